@@ design/lgrs_pkg.sv @@
// Package for the life generation row stepper.
// Holds the row width, the queued job type and the B3/S23 row rule.
// No dependencies.
package lgrs_pkg;

  // Every row is carried as a fixed 64-cell word.
  localparam int unsigned RowWidth = 64;
  localparam int unsigned ColWidth = 7;

  typedef logic [RowWidth-1:0] row_t;
  typedef logic [ColWidth-1:0] col_t;

  // One unit of back-end work, made by the front from one input beat.
  // With has_first set, the first result uses up, mid and down.
  // With last set, a flush result follows that uses mid and down over a dead row.
  typedef struct packed {
    row_t up;
    row_t mid;
    row_t down;
    logic has_first;
    logic last;
  } lgrs_job_t;

  // Next generation of the middle row, with all three rows masked to the grid width.
  function automatic row_t life_row(input row_t up_in, input row_t mid_in,
                                    input row_t down_in, input row_t mask);
    row_t       up;
    row_t       mid;
    row_t       down;
    row_t       res;
    logic [3:0] n;
    up   = up_in & mask;
    mid  = mid_in & mask;
    down = down_in & mask;
    res  = '0;
    for (int i = 0; i < RowWidth; i++) begin
      n = 4'(up[i]) + 4'(down[i]);
      if (i > 0) begin
        n = n + 4'(up[i-1]) + 4'(mid[i-1]) + 4'(down[i-1]);
      end
      if (i < RowWidth - 1) begin
        n = n + 4'(up[i+1]) + 4'(mid[i+1]) + 4'(down[i+1]);
      end
      res[i] = (n == 4'd3) || (mid[i] && (n == 4'd2));
    end
    return res & mask;
  endfunction

endpackage

@@ design/lgrs_front.sv @@
// Front end of the life generation row stepper: takes row beats and builds jobs.
// Holds the row above and the centre row. Depends on lgrs_pkg.
module lgrs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  lgrs_pkg::row_t    row_masked,
  input  logic              last_row,
  output logic              push,
  output lgrs_pkg::lgrs_job_t job,
  output logic              held
);
  import lgrs_pkg::*;

  row_t row_above;
  row_t row_centre;
  logic centre_held;

  // A job exists when a centre row is waiting or the frame ends here.
  always_comb begin
    job.up        = row_above;
    job.mid       = row_centre;
    job.down      = row_masked;
    job.has_first = centre_held;
    job.last      = last_row;
    push          = accept && (centre_held || last_row);
  end

  assign held = centre_held;

  // Window of rows; the end of a frame returns it to the empty state.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_above   <= '0;
      row_centre  <= '0;
      centre_held <= 1'b0;
    end else if (accept) begin
      if (last_row) begin
        row_above   <= '0;
        row_centre  <= '0;
        centre_held <= 1'b0;
      end else begin
        row_above   <= centre_held ? row_centre : '0;
        row_centre  <= row_masked;
        centre_held <= 1'b1;
      end
    end
  end

endmodule

@@ design/lgrs_queue.sv @@
// Two-entry job queue between the front and back ends.
// Depends on lgrs_pkg for the job type.
module lgrs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lgrs_pkg::lgrs_job_t push_job,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output lgrs_pkg::lgrs_job_t head
);
  import lgrs_pkg::*;

  lgrs_job_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ design/lgrs_back.sv @@
// Back end of the life generation row stepper: runs queued jobs into result beats.
// Computes one row per cycle into an output register while the output is not stalled. Depends on lgrs_pkg.
module lgrs_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  lgrs_pkg::lgrs_job_t job,
  input  lgrs_pkg::row_t      mask,
  output logic                pop,
  output logic                flush_pending,
  output logic                out_valid,
  input  logic                out_ready,
  output lgrs_pkg::row_t      next_row_cells,
  output logic                frame_last
);
  import lgrs_pkg::*;

  logic phase;
  logic load;
  logic do_first;
  row_t sel_up;
  row_t sel_mid;
  row_t sel_down;
  row_t result;

  // Pick the centre-row result first, the flush result after it.
  always_comb begin
    load     = job_valid && (!out_valid || out_ready);
    do_first = !phase && job.has_first;
    if (do_first) begin
      sel_up   = job.up;
      sel_mid  = job.mid;
      sel_down = job.down;
    end else begin
      sel_up   = job.mid;
      sel_mid  = job.down;
      sel_down = '0;
    end
    result = life_row(sel_up, sel_mid, sel_down, mask);
    pop    = load && !(do_first && job.last);
  end

  assign flush_pending = phase;

  // Output register and flush phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= do_first && job.last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      next_row_cells <= result;
      frame_last     <= !do_first;
    end
  end

endmodule

@@ design/life_generation_row_stepper_unit.sv @@
// Life generation row stepper: one B3/S23 generation on a bounded grid, row by row.
// A row's result is registered at the output once the row below is accepted.
// Throughput: one row beat per cycle while in_ready holds; a frame end adds a flushed row,
// from the single life-rule unit in the back end, one row per cycle when not stalled.
// Reset (synchronous) empties the row window and queue and sets cols_in_use to 64.
module life_generation_row_stepper_unit #(
  parameter int unsigned ROW_CELLS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  lgrs_pkg::col_t        cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lgrs_pkg::row_t        row_cells,
  input  logic                  last_row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lgrs_pkg::row_t        next_row_cells,
  output logic                  frame_last
);
  import lgrs_pkg::*;

  localparam col_t ColLimit = col_t'(ROW_CELLS);

  col_t      cols_in_use;
  col_t      cols_eff;
  row_t      mask;
  logic      accept;
  logic      push;
  lgrs_job_t push_job;
  logic      held;
  logic      pop;
  logic      q_full;
  logic      q_not_empty;
  lgrs_job_t head;
  logic      flush_pending;

  // Width register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= col_t'(RowWidth);
    end else if (cfg_we) begin
      cols_in_use <= cfg_wdata;
    end
  end

  // Grid mask, with the width saturated to the row size.
  always_comb begin
    cols_eff = (cols_in_use > ColLimit) ? ColLimit : cols_in_use;
    for (int i = 0; i < RowWidth; i++) begin
      mask[i] = (col_t'(i) < cols_eff);
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  lgrs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .row_masked (row_cells & mask),
    .last_row   (last_row),
    .push       (push),
    .job        (push_job),
    .held       (held)
  );

  lgrs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  lgrs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (q_not_empty),
    .job            (head),
    .mask           (mask),
    .pop            (pop),
    .flush_pending  (flush_pending),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .next_row_cells (next_row_cells),
    .frame_last     (frame_last)
  );

`ifndef SYNTH
  // A pending flush always has its job still at the head of the queue.
  a_flush_has_job: assert property (@(posedge clk) disable iff (rst)
    flush_pending |-> q_not_empty)
    else $error("flush pending with empty queue");

  // Accepting the bottom row empties the row window.
  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_row |=> !held)
    else $error("row window not cleared at frame end");

  // A result beat marked last is only ever produced by the flush path.
  a_last_from_flush: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && frame_last |-> $past(head.last))
    else $error("frame_last without a flushed job");
`endif

endmodule

@@ test/tb_life_generation_row_stepper_unit.sv @@
// Testbench for life_generation_row_stepper_unit: rows stream in with random gaps and
// output stalls, and each next-generation row is checked against an in-bench predictor.
// Depends on lgrs_pkg and the life_generation_row_stepper_unit RTL.
module tb_life_generation_row_stepper_unit;
  import lgrs_pkg::*;

  localparam int unsigned LimitCycles = 300_000;

  typedef struct packed {
    row_t cells;
    logic last;
  } next_row_t;

  // Tracks the row window, predicts the next-generation rows and checks them in order.
  class life_scoreboard;
    row_t      above;
    row_t      centre;
    bit        held;
    col_t      cols;
    next_row_t due_q[$];
    int        errors;
    int        seen;

    function new();
      above  = '0;
      centre = '0;
      held   = 1'b0;
      cols   = col_t'(RowWidth);
      errors = 0;
      seen   = 0;
    endfunction

    function void set_cols(col_t value);
      cols = value;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Columns at or above the grid width are dead; widths past the row saturate.
    function row_t grid_mask();
      if (cols >= RowWidth) return '1;
      return (row_t'(1) << cols) - row_t'(1);
    endfunction

    // Neighbor count over rows padded with a dead column on each side.
    function row_t life_next(row_t up, row_t mid, row_t down);
      row_t              mk;
      row_t              res;
      logic [RowWidth+1:0] u;
      logic [RowWidth+1:0] m;
      logic [RowWidth+1:0] d;
      int                n;
      mk  = grid_mask();
      u   = {1'b0, up & mk, 1'b0};
      m   = {1'b0, mid & mk, 1'b0};
      d   = {1'b0, down & mk, 1'b0};
      res = '0;
      for (int i = 0; i < RowWidth; i++) begin
        n = int'(u[i]) + int'(u[i+1]) + int'(u[i+2]) + int'(m[i]) + int'(m[i+2])
            + int'(d[i]) + int'(d[i+1]) + int'(d[i+2]);
        res[i] = (n == 3) || (m[i+1] && n == 2);
      end
      return res & mk;
    endfunction

    // One accepted row beat: the held row resolves, and a last row also flushes.
    function void note_row(row_t cells, logic last);
      row_t row;
      row = cells & grid_mask();
      if (held) begin
        due_q.push_back('{cells: life_next(above, centre, row), last: 1'b0});
        above = centre;
      end else begin
        above = '0;
      end
      centre = row;
      held   = 1'b1;
      if (last) begin
        due_q.push_back('{cells: life_next(above, centre, '0), last: 1'b1});
        above  = '0;
        centre = '0;
        held   = 1'b0;
      end
    endfunction

    task report_mismatch(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(row_t cells, logic last);
      next_row_t want;
      if (due_q.size() == 0) begin
        report_mismatch($sformatf("result %0d (%h, last %b) arrived with none expected",
                                  seen, cells, last));
        seen++;
        return;
      end
      want = due_q.pop_front();
      if (cells !== want.cells) begin
        report_mismatch($sformatf("result %0d next_row_cells %h, expected %h",
                                  seen, cells, want.cells));
      end
      if (last !== want.last) begin
        report_mismatch($sformatf("result %0d frame_last %b, expected %b",
                                  seen, last, want.last));
      end
      seen++;
    endtask

    task flush_leftovers();
      while (due_q.size() != 0) begin
        report_mismatch($sformatf("expected row %h (last %b) never arrived",
                                  due_q[0].cells, due_q[0].last));
        void'(due_q.pop_front());
      end
    endtask
  endclass

  logic clk       = 1'b0;
  logic rst;
  logic cfg_we;
  col_t cfg_wdata;
  logic in_valid;
  logic in_ready;
  row_t row_cells;
  logic last_row;
  logic out_valid;
  logic out_ready = 1'b0;
  row_t next_row_cells;
  logic frame_last;

  life_scoreboard sb;
  int             rows_sent    = 0;
  bit             tx_idle_on   = 1'b0;
  bit             rx_idle_on   = 1'b0;
  int             rx_stall_left = 0;
  int             frame_rows   = 0;
  int             frame_height = 0;

  life_generation_row_stepper_unit #(
    .ROW_CELLS(RowWidth)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .row_cells     (row_cells),
    .last_row      (last_row),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .next_row_cells(next_row_cells),
    .frame_last    (frame_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int tx_gap();
    if ($urandom_range(0, 99) < 65) return 0;
    return idle_len();
  endfunction

  // Row contents: plain random, sparse, dense, and the two uniform rows.
  function automatic row_t random_row();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 5) return {$urandom, $urandom};
    if (kind < 7) return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    if (kind < 9) return {$urandom, $urandom} | {$urandom, $urandom};
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  // Widths favor the edges: none, one, full, beyond full.
  function automatic col_t random_cols();
    case ($urandom_range(0, 9))
      0: return col_t'(0);
      1: return col_t'(1);
      2: return col_t'(RowWidth);
      3: return '1;
      4: return col_t'($urandom_range(RowWidth + 1, 127));
      5: return col_t'($urandom_range(2, 3));
      default: return col_t'($urandom_range(1, RowWidth));
    endcase
  endfunction

  // Sink side: ready drops for random stretches while stalling is enabled.
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      out_ready <= 1'b0;
      rx_stall_left--;
    end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
      out_ready <= 1'b0;
      rx_stall_left = idle_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every output beat is checked at the edge where it is taken.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(next_row_cells, frame_last);
  end

  // Presents one row beat and holds it until the block takes it.
  task automatic drive_row(input row_t cells, input logic last);
    int gap;
    gap = tx_idle_on ? tx_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    row_cells <= cells;
    last_row  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_row(cells, last);
    rows_sent++;
  endtask

  // The width changes only once every expected row is out and the pipeline has drained.
  task automatic write_cols(input col_t value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_cols(value);
  endtask

  // Random frames; a frame may stay open across a width change.
  task automatic send_frames(input int count);
    int   r;
    logic last;
    for (int k = 0; k < count; k++) begin
      if (frame_height == 0) begin
        r = $urandom_range(0, 99);
        if (r < 10) frame_height = 1;
        else if (r < 85) frame_height = $urandom_range(2, 6);
        else frame_height = $urandom_range(7, 20);
      end
      frame_rows++;
      last = (frame_rows == frame_height);
      drive_row(random_row(), last);
      if (last) begin
        frame_rows   = 0;
        frame_height = 0;
      end
    end
  endtask

  initial begin
    sb        = new();
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    row_cells = '0;
    last_row  = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset width first, single-row frame of all live cells.
    drive_row('1, 1'b1);
    // Full rows around a dead row.
    drive_row('1, 1'b0);
    drive_row('0, 1'b0);
    drive_row('1, 1'b1);
    // Vertical blinker under a dead top row.
    drive_row('0, 1'b0);
    drive_row(row_t'(1) << 5, 1'b0);
    drive_row(row_t'(1) << 5, 1'b0);
    drive_row(row_t'(1) << 5, 1'b1);
    // Blocks at both grid edges.
    drive_row({2'b11, {(RowWidth - 4){1'b0}}, 2'b11}, 1'b0);
    drive_row({2'b11, {(RowWidth - 4){1'b0}}, 2'b11}, 1'b0);
    drive_row({1'b1, {(RowWidth - 2){1'b0}}, 1'b1}, 1'b1);
    // No columns at all.
    write_cols(col_t'(0));
    drive_row('1, 1'b0);
    drive_row('1, 1'b1);
    // A width beyond the row saturates to the full row.
    write_cols('1);
    drive_row('1, 1'b0);
    drive_row({$urandom, $urandom}, 1'b1);
    // Narrow grid.
    write_cols(col_t'(3));
    drive_row('1, 1'b0);
    drive_row('1, 1'b0);
    drive_row('1, 1'b1);
    // Width shrinks while a row is held.
    write_cols(col_t'(RowWidth));
    drive_row('1, 1'b0);
    write_cols(col_t'(1));
    drive_row('1, 1'b1);
    write_cols(col_t'(2));
    drive_row('1, 1'b0);
    drive_row('1, 1'b1);

    // Random phases with mixed widths and handshake pressure.
    while (rows_sent < 520) begin
      if ($urandom_range(0, 9) < 6) write_cols(random_cols());
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      send_frames($urandom_range(3, 20));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.flush_leftovers();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(LimitCycles * 20);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
